FILE: hw/rtl/shs_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
`timescale 1ns / 1ps

package shs_pkg;

  typedef enum logic [1:0] {
    SRC_DATA  = 2'd0,
    SRC_PAD80 = 2'd1,
    SRC_ZERO  = 2'd2,
    SRC_LEN   = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      load_byte;
    byte_src_t src;
    logic      init;
    logic      round;
    logic [5:0] rnd;
    logic      add;
    logic      out_shift;
    logic [2:0] out_idx;
  } dp_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    big_sigma0 = ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    big_sigma1 = ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    small_sigma0 = ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    small_sigma1 = ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
  endfunction

endpackage

FILE: hw/rtl/shs_datapath.sv
// Datapath: block window, message schedule, round registers, hash state and bit count.
`timescale 1ns / 1ps

module shs_datapath
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  output logic [31:0] digest_word
);

  logic [31:0] win [16];
  logic [31:0] hv [8];
  logic [31:0] wv [8];
  logic [63:0] bits;

  logic [7:0]  byte_in;
  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    case (cmd.src)
      SRC_DATA:  byte_in = data_byte;
      SRC_PAD80: byte_in = PAD_BYTE;
      SRC_ZERO:  byte_in = 8'h00;
      SRC_LEN:   byte_in = bits[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  assign sched_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign t1 = wv[7] + big_sigma1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
            + ROUND_K[cmd.rnd] + win[0];
  assign t2 = big_sigma0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      for (int k = 0; k < 15; k++) begin
        win[k] <= {win[k][23:0], win[k+1][31:24]};
      end
      win[15] <= {win[15][23:0], byte_in};
    end else if (cmd.round) begin
      for (int k = 0; k < 15; k++) begin
        win[k] <= win[k+1];
      end
      win[15] <= sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int k = 0; k < 8; k++) begin
        wv[k] <= hv[k];
      end
    end else if (cmd.round) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) begin
        hv[k] <= IV[k];
      end
      bits <= '0;
    end else begin
      if (cmd.add) begin
        for (int k = 0; k < 8; k++) begin
          hv[k] <= hv[k] + wv[k];
        end
      end else if (cmd.out_shift) begin
        for (int k = 0; k < 7; k++) begin
          hv[k] <= hv[k+1];
        end
        hv[7] <= IV[cmd.out_idx];
      end
      // The length bytes leave from the top, so the count is back at zero after the eighth.
      if (cmd.load_byte && cmd.src == SRC_DATA) begin
        bits <= bits + 64'd8;
      end else if (cmd.load_byte && cmd.src == SRC_LEN) begin
        bits <= {bits[55:0], 8'h00};
      end
    end
  end

  assign digest_word = hv[0];

endmodule

FILE: hw/rtl/shs_ctrl.sv
// Controller: sequences byte loads, padding, compression rounds and digest output.
`timescale 1ns / 1ps

module shs_ctrl
  import shs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tuser,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  output logic    m_tlast,
  output dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [5:0] fill, fill_next;
  logic [5:0] cnt, cnt_next;
  logic       pad_first, pad_first_next;
  logic       pad_phase, pad_phase_next;
  logic       final_blk, final_blk_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tlast  = (state == ST_OUT) && (cnt[2:0] == 3'd7);

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    cnt_next       = cnt;
    pad_first_next = pad_first;
    pad_phase_next = pad_phase;
    final_blk_next = final_blk;
    cmd            = '0;
    cmd.src        = SRC_DATA;
    cmd.rnd        = cnt;
    cmd.out_idx    = cnt[2:0];
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            pad_first_next = 1'b1;
            state_next     = ST_PAD;
          end else begin
            cmd.load_byte = 1'b1;
            cmd.src       = SRC_DATA;
            fill_next     = fill + 6'd1;
            if (fill == 6'd63) begin
              cmd.init   = 1'b1;
              state_next = ST_ROUND;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.load_byte  = 1'b1;
        cmd.src        = pad_first ? SRC_PAD80 : SRC_ZERO;
        pad_first_next = 1'b0;
        fill_next      = fill + 6'd1;
        if (fill == 6'd63) begin
          cmd.init       = 1'b1;
          pad_phase_next = 1'b1;
          state_next     = ST_ROUND;
        end else if (fill == 6'd55) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.load_byte = 1'b1;
        cmd.src       = SRC_LEN;
        fill_next     = fill + 6'd1;
        if (fill == 6'd63) begin
          cmd.init       = 1'b1;
          final_blk_next = 1'b1;
          state_next     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cnt_next  = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (final_blk) begin
          final_blk_next = 1'b0;
          pad_phase_next = 1'b0;
          state_next     = ST_OUT;
        end else if (pad_phase) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (m_tready) begin
          cmd.out_shift = 1'b1;
          if (cnt[2:0] == 3'd7) begin
            cnt_next   = '0;
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 6'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      cnt       <= '0;
      pad_first <= 1'b0;
      pad_phase <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      cnt       <= cnt_next;
      pad_first <= pad_first_next;
      pad_phase <= pad_phase_next;
      final_blk <= final_blk_next;
    end
  end

  a_round_full_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (fill == 6'd0))
    else $error("compression running on a partly filled block");

  a_add_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |=> (state != ST_ADD))
    else $error("feed-forward add held for more than one cycle");

  a_len_position: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> (fill[5:3] == 3'd7))
    else $error("length bytes outside the last eight block positions");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT || state == ST_ROUND) |-> !s_tready)
    else $error("input accepted while compressing or emitting the digest");

  a_out_counter: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (cnt[5:3] == 3'd0))
    else $error("digest word counter out of range");

endmodule

FILE: hw/rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher.
`timescale 1ns / 1ps
//
// The slave channel takes one transaction per message byte: s_tuser low absorbs
// s_tdata, s_tuser high finishes the message (s_tdata is ignored then).
// The master channel returns the 256-bit digest as eight 32-bit transactions,
// most significant word first, with m_tlast on the eighth.
// Every 64th byte starts a compression of 64 rounds plus one feed-forward add,
// during which s_tready is low; a single shared round unit does the rounds in turn.
// A finish writes padding and length one byte per cycle, pausing to compress
// when padding spills into a second block; each padded block is compressed, and
// the first digest word is valid the cycle after the last feed-forward add.
// While the digest is presented, no input is taken; a stalled receiver holds
// m_tvalid and the word in place. After the eighth word is taken the hash state
// is back at its initial value and a new message may start.
// Reset (rst, synchronous, active high) loads the initial hash values and
// clears the byte and bit counts; it needs no clearing sweep.
//

module sha256_stream_hasher
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tuser,  // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] digest_word
  output logic        m_tlast
);

  dp_cmd_t cmd;

  shs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd)
  );

  shs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_tdata),
    .digest_word (m_tdata)
  );

endmodule
